// ----- rtl/core/rsr_pkg.sv -----
// Shared types, constants and the cosine weight table for the reverse slice repeater.
// No dependencies.
package rsr_pkg;

	localparam int RING_DEPTH_DEF   = 65536;
	localparam int FREEZE_DEPTH_DEF = 65536;
	localparam int SAMPLE_W         = 16;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 16;
	localparam logic [14:0] FADE_DONE = 15'h7fff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLICE_LEN    = 2'd0,
		REG_REPEAT_LIMIT = 2'd1,
		REG_FADE_LEN     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIV,
		ST_WPROD,
		ST_WSUM,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} seq_state_t;

	typedef logic [16:0] weight_t;

	// raised-cosine weights in Q1.16, 17 points
	function automatic weight_t cos_weight(input logic [4:0] k);
		weight_t w;
		case (k)
			5'd0:  w = 17'd0;
			5'd1:  w = 17'd630;
			5'd2:  w = 17'd2494;
			5'd3:  w = 17'd5522;
			5'd4:  w = 17'd9598;
			5'd5:  w = 17'd14563;
			5'd6:  w = 17'd20228;
			5'd7:  w = 17'd26375;
			5'd8:  w = 17'd32768;
			5'd9:  w = 17'd39161;
			5'd10: w = 17'd45308;
			5'd11: w = 17'd50973;
			5'd12: w = 17'd55938;
			5'd13: w = 17'd60014;
			5'd14: w = 17'd63042;
			5'd15: w = 17'd64906;
			default: w = 17'd65536;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/reverse_slice_repeater_unit.sv -----
// Top level of the reverse slice repeater: ring store, freeze store and fade datapath.
// Depends on rsr_pkg.
//
// Usage: one signed Q1.15 sample word enters per handshake on in_valid/in_stall,
// and exactly one processed word leaves on out_valid/out_stall with is_playing.
// Registers (slice_len, repeat_limit, fade_len) are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce. A word with no fade running goes from
// ST_FETCH straight to ST_DONE; a word inside a fade first runs the 16-step fade
// phase divider and the weight / blend multiplier stages. No new word is accepted
// until the current word's result has left ST_DONE.
// When a slice is captured the block copies it from the ring to the freeze store,
// one sample a cycle through the ring read port, so in_stall stays high until the
// whole slice is copied, which starts when that word's result is registered.
// The output register parts the two sides; while out_stall holds a finished word
// the block accepts the next word and parks it once its result is ready.
// Reset clears all control state and selects recording mode; the stores are not
// cleared and their contents are undefined until written.
module reverse_slice_repeater_unit #(
	parameter int RING_DEPTH   = rsr_pkg::RING_DEPTH_DEF,
	parameter int FREEZE_DEPTH = rsr_pkg::FREEZE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [rsr_pkg::SAMPLE_W-1:0]   in_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [rsr_pkg::SAMPLE_W-1:0]   out_sample,
	output logic                            is_playing,
	input  logic                            cfg_wr_en,
	input  logic [rsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import rsr_pkg::*;

	localparam int RA_W = $clog2(RING_DEPTH);
	localparam int FA_W = $clog2(FREEZE_DEPTH);
	localparam int CAP_I = (RING_DEPTH < FREEZE_DEPTH ? RING_DEPTH : FREEZE_DEPTH) - 1;
	localparam int CAP_C = CAP_I > 65535 ? 65535 : CAP_I;
	localparam logic [15:0] SLICE_CAP = 16'(CAP_C);
	localparam logic [RA_W-1:0] RING_LAST = RA_W'(RING_DEPTH - 1);
	localparam logic [RA_W:0]   RING_SPAN = (RA_W+1)'(RING_DEPTH);

	// configuration registers
	logic [15:0] slice_len_q;
	logic [2:0]  repeat_limit_q;
	logic [13:0] fade_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_len_q    <= 16'd24000;
			repeat_limit_q <= 3'd1;
			fade_len_q     <= 14'd32;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SLICE_LEN:    slice_len_q    <= cfg_wdata;
				REG_REPEAT_LIMIT: repeat_limit_q <= cfg_wdata[2:0];
				REG_FADE_LEN:     fade_len_q     <= cfg_wdata[13:0];
				default: ;
			endcase
		end
	end

	// effective slice and fade lengths
	logic [15:0] sl_eff;
	logic [13:0] fl_eff;
	always_comb begin
		sl_eff = slice_len_q;
		if (sl_eff < 16'd2) sl_eff = 16'd2;
		if (sl_eff > SLICE_CAP) sl_eff = SLICE_CAP;
		fl_eff = fade_len_q;
		if (16'(fl_eff) > (sl_eff >> 2)) fl_eff = 14'(sl_eff >> 2);
		if (fl_eff == 14'd0) fl_eff = 14'd1;
	end

	// control state
	seq_state_t state_q, state_d;
	logic          copy_q;
	logic [RA_W-1:0] wi_q;
	logic          mode_q;
	logic [15:0]   cap_len_q;
	logic [15:0]   play_idx_q;
	logic [15:0]   rec_cnt_q;
	logic [2:0]    pass_q;
	logic [14:0]   entry_pos_q, exit_pos_q;
	logic signed [SAMPLE_W-1:0] entry_from_q, exit_from_q;

	// per-word working registers
	logic signed [SAMPLE_W-1:0] x_q, v_q, from_q, y_q;
	logic [14:0]   fpos_q;
	logic [13:0]   flen_q;
	logic [14:0]   rem_q;
	logic [15:0]   quo_q;
	logic [3:0]    div_cnt_q;
	logic [24:0]   wprod_q;
	logic [3:0]    widx_q;
	weight_t       w_q;
	logic signed [33:0] p_from_q, p_x_q;

	// slice copy sweep
	logic [15:0]   ci_q, wc_q;
	logic [RA_W-1:0] rp_q;
	logic          cvld_s1;

	// output register
	logic          out_valid_q, is_playing_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign is_playing = is_playing_q;

	logic in_acc, emit, copy_done, fade_on;
	assign in_acc    = in_valid && !in_stall;
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign copy_done = copy_q && (ci_q == cap_len_q) && !cvld_s1;
	assign fade_on   = fpos_q < 15'(flen_q);
	assign in_stall  = (state_q != ST_IDLE) || copy_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_FETCH;
			ST_FETCH: state_d = fade_on ? ST_DIV : ST_DONE;
			ST_DIV:   if (div_cnt_q == 4'hf) state_d = ST_WPROD;
			ST_WPROD: state_d = ST_WSUM;
			ST_WSUM:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DONE;
			ST_DONE:  if (emit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// stores
	logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic signed [SAMPLE_W-1:0] frz_mem [FREEZE_DEPTH];
	logic signed [SAMPLE_W-1:0] ring_rd_q, frz_rd_q;

	always_ff @(posedge clk) begin
		if (in_acc) ring_mem[wi_q] <= in_sample;
		ring_rd_q <= ring_mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (cvld_s1) frz_mem[FA_W'(wc_q)] <= ring_rd_q;
		frz_rd_q <= frz_mem[FA_W'(cap_len_q - 16'd1 - play_idx_q)];
	end

	// fade datapath
	logic [15:0]   rem2;
	weight_t       t_lo;
	logic [16:0]   inv_w;
	logic signed [34:0] bsum;
	logic signed [18:0] bres;
	logic signed [SAMPLE_W-1:0] bclip;

	always_comb begin
		rem2  = {rem_q, 1'b0};
		t_lo  = cos_weight({1'b0, widx_q});
		inv_w = 17'h10000 - w_q;
		bsum  = 35'(p_from_q) + 35'(p_x_q) + 35'sd32768;
		bres  = 19'(bsum >>> 16);
		if (bres > 19'sd32767)       bclip = 16'sh7fff;
		else if (bres < -19'sd32768) bclip = -16'sh8000;
		else                         bclip = 16'(bres);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q    <= in_sample;
				flen_q <= fl_eff;
				fpos_q <= mode_q ? entry_pos_q : exit_pos_q;
				from_q <= mode_q ? entry_from_q : exit_from_q;
			end
			ST_FETCH: begin
				v_q       <= mode_q ? frz_rd_q : x_q;
				y_q       <= mode_q ? frz_rd_q : x_q;
				rem_q     <= fpos_q;
				quo_q     <= 16'd0;
				div_cnt_q <= 4'd0;
			end
			ST_DIV: begin
				// one restoring step: phase = pos * 65536 / len
				if (rem2 >= 16'(flen_q)) begin
					rem_q <= 15'(rem2 - 16'(flen_q));
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem2[14:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			ST_WPROD: begin
				widx_q  <= quo_q[15:12];
				wprod_q <= 25'(13'(cos_weight({1'b0, quo_q[15:12]} + 5'd1)
					- cos_weight({1'b0, quo_q[15:12]}))) * 25'(quo_q[11:0]);
			end
			ST_WSUM: begin
				w_q <= t_lo + 17'((wprod_q + 25'd2048) >> 12);
			end
			ST_MUL: begin
				p_from_q <= from_q * $signed({1'b0, inv_w});
				p_x_q    <= v_q * $signed({1'b0, w_q});
			end
			ST_SUM: y_q <= bclip;
			default: ;
		endcase
	end

	// state update, output register and slice copy
	logic [15:0] rc_inc, pi_inc;
	logic [2:0]  pass_inc;
	logic [RA_W:0] start_sum;
	always_comb begin
		rc_inc    = rec_cnt_q + 16'd1;
		pi_inc    = play_idx_q + 16'd1;
		pass_inc  = pass_q + 3'd1;
		// wi was already advanced past the current word when the copy begins
		start_sum = {1'b0, wi_q} + RING_SPAN - (RA_W+1)'(sl_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			is_playing_q <= 1'b0;
			out_sample_q <= '0;
			copy_q       <= 1'b0;
			wi_q         <= '0;
			mode_q       <= 1'b0;
			cap_len_q    <= '0;
			play_idx_q   <= '0;
			rec_cnt_q    <= '0;
			pass_q       <= '0;
			entry_pos_q  <= FADE_DONE;
			exit_pos_q   <= FADE_DONE;
			entry_from_q <= '0;
			exit_from_q  <= '0;
			ci_q         <= '0;
			wc_q         <= '0;
			rp_q         <= '0;
			cvld_s1      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (in_acc) wi_q <= (wi_q == RING_LAST) ? '0 : wi_q + RA_W'(1);
			if (emit) begin
				out_valid_q  <= 1'b1;
				out_sample_q <= y_q;
				is_playing_q <= mode_q;
				if (!mode_q) begin
					if (fade_on) exit_pos_q <= exit_pos_q + 15'd1;
					rec_cnt_q <= rc_inc;
					if (rc_inc >= sl_eff) begin
						// capture: start the ring to freeze copy
						cap_len_q    <= sl_eff;
						play_idx_q   <= '0;
						pass_q       <= '0;
						entry_pos_q  <= '0;
						entry_from_q <= y_q;
						mode_q       <= 1'b1;
						rec_cnt_q    <= '0;
						copy_q       <= 1'b1;
						ci_q         <= '0;
						wc_q         <= '0;
						// slice ends just before the current word at wi - 1
						rp_q <= (start_sum >= RING_SPAN + (RA_W+1)'(1))
							? RA_W'(start_sum - RING_SPAN - (RA_W+1)'(1))
							: ((start_sum == '0) ? RING_LAST
							: RA_W'(start_sum - (RA_W+1)'(1)));
					end
				end else begin
					if (fade_on) entry_pos_q <= entry_pos_q + 15'd1;
					play_idx_q <= pi_inc;
					if (pi_inc >= cap_len_q) begin
						play_idx_q   <= '0;
						entry_pos_q  <= '0;
						entry_from_q <= y_q;
						pass_q       <= pass_inc;
						if (pass_inc >= repeat_limit_q) begin
							mode_q      <= 1'b0;
							rec_cnt_q   <= '0;
							entry_pos_q <= 15'(flen_q);
							exit_pos_q  <= '0;
							exit_from_q <= y_q;
						end
					end
				end
			end
			// copy sweep: read ring at rp, write freeze in the next cycle
			if (copy_q) begin
				cvld_s1 <= ci_q != cap_len_q;
				if (ci_q != cap_len_q) begin
					ci_q <= ci_q + 16'd1;
					rp_q <= (rp_q == RING_LAST) ? '0 : rp_q + RA_W'(1);
				end
				if (cvld_s1) wc_q <= wc_q + 16'd1;
				if (copy_done) copy_q <= 1'b0;
			end
		end
	end

endmodule
